[sv/mau_pkg.sv]
// Shared types, operation codes and controller states of the modular arithmetic unit.
package mau_pkg;

   typedef enum logic [3:0] {
      OP_REDUCE = 4'd0,
      OP_ADD    = 4'd1,
      OP_SUB    = 4'd2,
      OP_MUL    = 4'd3,
      OP_DIV    = 4'd4,
      OP_POW    = 4'd5,
      OP_INV    = 4'd6,
      OP_NEG    = 4'd7,
      OP_INC    = 4'd8,
      OP_DEC    = 4'd9,
      OP_EQUAL  = 4'd10
   } op_type;

   typedef struct packed {
      logic [3:0]  req_type;
      logic [30:0] operand_a;
      logic [30:0] operand_b;
      logic [63:0] raw_value;
      logic [62:0] exponent;
   } req_type_s_type;

   typedef struct packed {
      logic [30:0] residue;
      logic        equal_flag;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RED_A,
      ST_RED_B,
      ST_RED_RAW,
      ST_SIMPLE,
      ST_POW_SETUP,
      ST_POW_MUL,
      ST_POW_SQR,
      ST_FINAL_MUL,
      ST_DONE
   } state_type;

   // Datapath command codes: load, operand reductions, simple operation, power setup and multiply.
   typedef enum logic [2:0] {
      DP_NONE,
      DP_LOAD,
      DP_RED_A,
      DP_RED_B,
      DP_RED_RAW,
      DP_SIMPLE,
      DP_POW_SETUP,
      DP_MUL
   } dp_cmd_code_type;

   typedef enum logic [1:0] {
      MS_ACC_BASE,
      MS_BASE_BASE,
      MS_A_ACC
   } mul_sel_type;

   typedef struct packed {
      dp_cmd_code_type code;
      mul_sel_type     mul_sel;
      logic            pow_inv;
   } dp_cmd_type;

   typedef struct packed {
      logic red_done;
      logic mul_done;
      logic exp_zero;
      logic exp_lsb;
   } dp_status_type;

endpackage

[sv/modular_arithmetic_unit.sv]
// Top level of the modular arithmetic unit.
// Usage:
//  - req channel (req_valid/req_stall/req_payload) carries one operation with operands.
//  - rsp channel (rsp_valid/rsp_stall/rsp_payload) returns one residue and equal flag.
//  - csr_write_enable/csr_write_data set the modulus; write only while idle.
// One request is in flight at a time. Each operand reduction runs through a
// bit-serial remainder unit; every modular multiplication forms one product and
// reduces it in that same unit. A power walks its 63-bit exponent bit by bit
// through the shared multiplier and remainder unit. A stalled response holds its
// payload and blocks the next request. Reset returns the modulus to 1000000007
// and the controller to idle.
module modular_arithmetic_unit #(
   parameter logic [30:0] RESET_MODULUS = 31'd1000000007
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  mau_pkg::req_type_s_type  req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output mau_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_write_enable,
   input  logic [30:0]              csr_write_data
);
   logic [30:0] modulus_ff;
   mau_pkg::dp_cmd_type    cmd;
   mau_pkg::dp_status_type status;

   always_ff @(posedge clock) begin
      if (reset) modulus_ff <= RESET_MODULUS;
      else if (csr_write_enable) modulus_ff <= csr_write_data;
   end

   mau_controller u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_op(req_payload.req_type), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .cmd(cmd), .status(status)
   );

   mau_datapath u_dp (
      .clock(clock), .reset(reset), .req(req_payload), .modulus(modulus_ff),
      .cmd(cmd), .status(status), .result(rsp_payload)
   );
endmodule

[sv/mau_reducer.sv]
// Bit-serial restoring remainder unit: 64-bit dividend modulo a 31-bit modulus.
module mau_reducer (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [30:0] modulus,
   output logic        done,
   output logic [30:0] remainder
);
   logic [31:0] rem_ff, rem_in;
   logic [63:0] shift_ff, shift_in;
   logic [6:0]  count_ff, count_in;
   logic        busy_ff, busy_in;
   logic [31:0] trial;
   logic [31:0] rem_step;

   always_comb begin
      rem_in   = rem_ff;
      shift_in = shift_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      trial    = {rem_ff[30:0], shift_ff[63]};
      // remainder stays below modulus, so trial is below twice modulus
      rem_step = (trial >= {1'b0, modulus}) ? trial - {1'b0, modulus} : trial;
      if (start) begin
         rem_in   = '0;
         shift_in = dividend;
         count_in = 7'd0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in   = rem_step;
         shift_in = {shift_ff[62:0], 1'b0};
         count_in = count_ff + 7'd1;
         if (count_ff == 7'd63) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
      rem_ff   <= rem_in;
      shift_ff <= shift_in;
   end

   assign done      = busy_ff && (count_ff == 7'd63);
   assign remainder = rem_step[30:0];
endmodule

[sv/mau_datapath.sv]
// Operand registers, shared multiplier and remainder unit of the modular arithmetic unit.
module mau_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  mau_pkg::req_type_s_type req,
   input  logic [30:0]             modulus,
   input  mau_pkg::dp_cmd_type     cmd,
   output mau_pkg::dp_status_type  status,
   output mau_pkg::rsp_payload_type result
);
   logic [30:0] m_eff;
   logic [3:0]  op_ff;
   logic [30:0] a_ff, a_in, b_ff, b_in, acc_ff, acc_in, base_ff, base_in;
   logic [63:0] raw_ff;
   logic [62:0] exp_ff, exp_in;
   logic [61:0] prod_in;
   logic        neg_ff;
   logic        red_start, red_done;
   logic [63:0] red_dividend;
   logic [30:0] red_rem;
   logic [30:0] mul_x, mul_y;
   logic [31:0] sum, dif;
   logic [30:0] simple;
   logic        eq_ff, eq_in;
   logic        pending_ff, pending_in;

   assign m_eff = (modulus < 31'd2) ? 31'd1 : modulus;

   always_comb begin
      case (cmd.mul_sel)
         mau_pkg::MS_ACC_BASE:  begin mul_x = acc_ff;  mul_y = base_ff; end
         mau_pkg::MS_BASE_BASE: begin mul_x = base_ff; mul_y = base_ff; end
         mau_pkg::MS_A_ACC:     begin mul_x = a_ff;    mul_y = acc_ff;  end
         default:               begin mul_x = acc_ff;  mul_y = base_ff; end
      endcase
   end

   always_comb begin
      sum = {1'b0, a_ff} + {1'b0, b_ff};
      dif = {1'b0, a_ff} - {1'b0, b_ff};
      simple = '0;
      case (mau_pkg::op_type'(op_ff))
         mau_pkg::OP_ADD: simple = (sum >= {1'b0, m_eff}) ? 31'(sum - {1'b0, m_eff})
                                                           : sum[30:0];
         mau_pkg::OP_SUB: simple = dif[31] ? 31'(dif + {1'b0, m_eff}) : dif[30:0];
         mau_pkg::OP_NEG: simple = (a_ff == 31'd0) ? 31'd0 : m_eff - a_ff;
         mau_pkg::OP_INC: simple = (a_ff + 31'd1 == m_eff) ? 31'd0 : a_ff + 31'd1;
         mau_pkg::OP_DEC: simple = (a_ff == 31'd0) ? m_eff - 31'd1 : a_ff - 31'd1;
         default:         simple = '0;
      endcase
   end

   always_comb begin
      red_start    = 1'b0;
      red_dividend = {33'd0, req.operand_a};
      case (cmd.code)
         mau_pkg::DP_LOAD: begin
            red_start = 1'b1;
            red_dividend = {33'd0, req.operand_a};
         end
         mau_pkg::DP_RED_A: begin
            red_start = red_done;
            red_dividend = {33'd0, b_ff};
         end
         mau_pkg::DP_RED_B: begin
            red_start = red_done;
            red_dividend = raw_ff[63] ? 64'd0 - raw_ff : raw_ff;
         end
         mau_pkg::DP_MUL: begin
            red_start = !pending_ff;
            red_dividend = {2'b00, prod_in};
         end
         default: ;
      endcase
   end

   mau_reducer u_red (
      .clock(clock), .reset(reset), .start(red_start), .dividend(red_dividend),
      .modulus(m_eff), .done(red_done), .remainder(red_rem)
   );

   always_comb begin
      a_in = a_ff; b_in = b_ff; acc_in = acc_ff; base_in = base_ff; exp_in = exp_ff;
      prod_in = {31'd0, mul_x} * {31'd0, mul_y};
      eq_in = eq_ff;
      pending_in = pending_ff;
      case (cmd.code)
         mau_pkg::DP_RED_A:   if (red_done) a_in = red_rem;
         mau_pkg::DP_RED_B:   if (red_done) begin
            b_in   = red_rem;
            acc_in = red_rem;
         end
         mau_pkg::DP_RED_RAW: if (red_done)
            acc_in = (neg_ff && red_rem != 31'd0) ? m_eff - red_rem : red_rem;
         mau_pkg::DP_SIMPLE: begin
            acc_in = simple;
            eq_in  = (mau_pkg::op_type'(op_ff) == mau_pkg::OP_EQUAL) && (a_ff == b_ff);
         end
         mau_pkg::DP_POW_SETUP: begin
            acc_in = (m_eff == 31'd1) ? 31'd0 : 31'd1;
            if (cmd.pow_inv) begin
               exp_in  = {32'd0, (m_eff >= 31'd2) ? m_eff - 31'd2 : 31'd0};
               base_in = (mau_pkg::op_type'(op_ff) == mau_pkg::OP_DIV) ? b_ff : a_ff;
            end else begin
               base_in = a_ff;
            end
         end
         mau_pkg::DP_MUL: begin
            // first cycle loads the product into the remainder unit
            pending_in = 1'b1;
            if (pending_ff && red_done) begin
               pending_in = 1'b0;
               case (cmd.mul_sel)
                  mau_pkg::MS_BASE_BASE: begin
                     base_in = red_rem;
                     exp_in  = {1'b0, exp_ff[62:1]};
                  end
                  default: acc_in = red_rem;
               endcase
            end
         end
         default: ;
      endcase
      if (cmd.code == mau_pkg::DP_LOAD) eq_in = 1'b0;
      if (cmd.code != mau_pkg::DP_MUL) pending_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
      end else begin
         pending_ff <= pending_in;
      end
      if (cmd.code == mau_pkg::DP_LOAD) begin
         op_ff  <= req.req_type;
         b_ff   <= req.operand_b;
         raw_ff <= req.raw_value;
         neg_ff <= req.raw_value[63];
         exp_ff <= req.exponent;
         a_ff   <= a_ff;
      end else begin
         a_ff   <= a_in;
         b_ff   <= b_in;
         exp_ff <= exp_in;
      end
      acc_ff  <= (cmd.code == mau_pkg::DP_LOAD) ? 31'd0 : acc_in;
      base_ff <= base_in;
      eq_ff   <= eq_in;
   end

   assign status.red_done = red_done && !(cmd.code == mau_pkg::DP_MUL && !pending_ff);
   assign status.mul_done = pending_ff && red_done;
   assign status.exp_zero = (exp_ff == 63'd0);
   assign status.exp_lsb  = exp_ff[0];
   assign result.residue    = acc_ff;
   assign result.equal_flag = eq_ff;
endmodule

[sv/mau_controller.sv]
// Sequencing state machine of the modular arithmetic unit.
module mau_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [3:0]             req_op,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output mau_pkg::dp_cmd_type    cmd,
   input  mau_pkg::dp_status_type status
);
   mau_pkg::state_type state_ff, state_in;
   logic [3:0] op_ff, op_in;
   logic       inv_ff, inv_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mau_pkg::ST_IDLE;
         op_ff    <= '0;
         inv_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         inv_ff   <= inv_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      inv_in      = inv_ff;
      cmd.code    = mau_pkg::DP_NONE;
      cmd.mul_sel = mau_pkg::MS_ACC_BASE;
      cmd.pow_inv = inv_ff;
      req_stall   = 1'b1;
      rsp_valid   = 1'b0;
      case (state_ff)
         mau_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.code = mau_pkg::DP_LOAD;
               op_in    = req_op;
               inv_in   = (req_op == mau_pkg::OP_INV) || (req_op == mau_pkg::OP_DIV);
               state_in = mau_pkg::ST_RED_A;
            end
         end
         mau_pkg::ST_RED_A: begin
            cmd.code = mau_pkg::DP_RED_A;
            if (status.red_done) state_in = mau_pkg::ST_RED_B;
         end
         mau_pkg::ST_RED_B: begin
            cmd.code = mau_pkg::DP_RED_B;
            if (status.red_done) begin
               if (op_ff == mau_pkg::OP_REDUCE) state_in = mau_pkg::ST_RED_RAW;
               else if (op_ff == mau_pkg::OP_POW || op_ff == mau_pkg::OP_INV ||
                        op_ff == mau_pkg::OP_DIV) state_in = mau_pkg::ST_POW_SETUP;
               else if (op_ff == mau_pkg::OP_MUL) state_in = mau_pkg::ST_FINAL_MUL;
               else state_in = mau_pkg::ST_SIMPLE;
            end
         end
         mau_pkg::ST_RED_RAW: begin
            cmd.code = mau_pkg::DP_RED_RAW;
            if (status.red_done) state_in = mau_pkg::ST_DONE;
         end
         mau_pkg::ST_SIMPLE: begin
            cmd.code = mau_pkg::DP_SIMPLE;
            state_in = mau_pkg::ST_DONE;
         end
         mau_pkg::ST_POW_SETUP: begin
            cmd.code = mau_pkg::DP_POW_SETUP;
            state_in = mau_pkg::ST_POW_MUL;
         end
         mau_pkg::ST_POW_MUL: begin
            if (status.exp_zero) begin
               state_in = (op_ff == mau_pkg::OP_DIV) ? mau_pkg::ST_FINAL_MUL
                                                     : mau_pkg::ST_DONE;
            end else if (status.exp_lsb) begin
               cmd.code    = mau_pkg::DP_MUL;
               cmd.mul_sel = mau_pkg::MS_ACC_BASE;
               if (status.mul_done) state_in = mau_pkg::ST_POW_SQR;
            end else begin
               state_in = mau_pkg::ST_POW_SQR;
            end
         end
         mau_pkg::ST_POW_SQR: begin
            cmd.code    = mau_pkg::DP_MUL;
            cmd.mul_sel = mau_pkg::MS_BASE_BASE;
            if (status.mul_done) state_in = mau_pkg::ST_POW_MUL;
         end
         mau_pkg::ST_FINAL_MUL: begin
            // a times acc: acc holds reduced b for multiply, the inverse for divide
            cmd.code    = mau_pkg::DP_MUL;
            cmd.mul_sel = mau_pkg::MS_A_ACC;
            if (status.mul_done) state_in = mau_pkg::ST_DONE;
         end
         mau_pkg::ST_DONE: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) state_in = mau_pkg::ST_IDLE;
         end
         default: state_in = mau_pkg::ST_IDLE;
      endcase
   end
endmodule

[sv/mau_checker.sv]
// Port-level checker for the modular arithmetic unit, bound to the top level.
module mau_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input mau_pkg::rsp_payload_type rsp_payload
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");
   a_no_req_during_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while response pending");
   a_accept_then_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall && !rsp_valid)
      else $error("no busy after accept");
   a_eq_residue: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.equal_flag |-> rsp_payload.residue == 31'd0)
      else $error("equal response with nonzero residue");
endmodule

bind modular_arithmetic_unit mau_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload)
);

[verif/tb_modular_arithmetic_unit.sv]
// Self-checking testbench for the modular arithmetic unit: directed table, then random phases.
module tb_modular_arithmetic_unit;

   localparam logic [3:0] OP_UNUSED_LO = 4'd11;
   localparam logic [3:0] OP_UNUSED_HI = 4'd15;
   localparam logic [30:0] RESET_MOD = 31'd1000000007;
   localparam logic [30:0] OPND_MAX = 31'h7FFFFFFE;
   localparam int CYCLE_LIMIT = 6000000;
   localparam int ITEMS_PER_PHASE = 87;

   typedef struct {
      logic [3:0]  kind;
      logic [30:0] a;
      logic [30:0] b;
      logic [63:0] raw;
      logic [62:0] e;
      bit          typed;
      logic [30:0] res;
      bit          flag;
   } dir_row_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   mau_pkg::req_type_s_type  req_payload;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   mau_pkg::rsp_payload_type rsp_payload;
   logic                     csr_write_enable;
   logic [30:0]              csr_write_data;

   mau_pkg::rsp_payload_type result_q[$];
   logic [30:0]              cur_modulus = RESET_MOD;
   bit                       drv_typed;
   mau_pkg::rsp_payload_type drv_result;
   int                       error_count = 0;
   int                       cycle_count = 0;
   bit                       long_hold_req = 1'b0;
   bit                       hold_taken = 1'b0;
   int                       hold_left = 0;
   int                       stall_mode = 0;
   int                       mode_left = 0;
   int                       burst_left;
   dir_row_type              rows[$];

   modular_arithmetic_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   function automatic longint unsigned pow_mod(longint unsigned base, longint unsigned e,
                                               longint unsigned m);
      longint unsigned acc;
      acc = 1 % m;
      while (e != 0) begin
         if (e[0]) acc = (acc * base) % m;
         base = (base * base) % m;
         e = e >> 1;
      end
      return acc;
   endfunction

   function automatic mau_pkg::rsp_payload_type predict_result(mau_pkg::req_type_s_type r,
                                                               logic [30:0] modulus);
      longint unsigned m, a, b, mag, res;
      mau_pkg::rsp_payload_type out;
      m = (modulus < 2) ? 1 : longint'(modulus);
      a = longint'(r.operand_a) % m;
      b = longint'(r.operand_b) % m;
      res = 0;
      out.equal_flag = 1'b0;
      case (r.req_type)
         mau_pkg::OP_REDUCE: begin
            if (r.raw_value[63]) begin
               mag = 64'd0 - r.raw_value;
               res = mag % m;
               res = (res == 0) ? 0 : m - res;
            end else begin
               res = r.raw_value % m;
            end
         end
         mau_pkg::OP_ADD:   res = (a + b) % m;
         mau_pkg::OP_SUB:   res = (a + m - b) % m;
         mau_pkg::OP_MUL:   res = (a * b) % m;
         mau_pkg::OP_DIV:   res = (a * pow_mod(b, (m >= 2) ? m - 2 : 0, m)) % m;
         mau_pkg::OP_POW:   res = pow_mod(a, {1'b0, r.exponent}, m);
         mau_pkg::OP_INV:   res = pow_mod(a, (m >= 2) ? m - 2 : 0, m);
         mau_pkg::OP_NEG:   res = (m - a) % m;
         mau_pkg::OP_INC:   res = (a + 1) % m;
         mau_pkg::OP_DEC:   res = (a + m - 1) % m;
         mau_pkg::OP_EQUAL: out.equal_flag = (a == b);
         default:           res = 0;
      endcase
      out.residue = res[30:0];
      return out;
   endfunction

   task automatic report(string what);
      $display("mismatch @%0d: %s", cycle_count, what);
      error_count++;
   endtask

   // request intake, modulus tracking, response checking
   always @(posedge clock) begin
      mau_pkg::rsp_payload_type want;
      if (reset) begin
         cur_modulus <= RESET_MOD;
      end else begin
         if (csr_write_enable) cur_modulus <= csr_write_data;
         if (req_valid && !req_stall)
            result_q.push_back(drv_typed ? drv_result : predict_result(req_payload, cur_modulus));
         if (rsp_valid && !rsp_stall) begin
            if (result_q.size() == 0) begin
               report("response with nothing outstanding");
            end else begin
               want = result_q.pop_front();
               if (rsp_payload.residue !== want.residue)
                  report($sformatf("residue %0d, want %0d", rsp_payload.residue, want.residue));
               if (rsp_payload.equal_flag !== want.equal_flag)
                  report($sformatf("equal_flag %0b, want %0b", rsp_payload.equal_flag,
                                   want.equal_flag));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("modular_arithmetic_unit regression: fail");
         $finish;
      end
   end

   // receiver: stall modes in stretches, plus one long hold on request
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (long_hold_req && !hold_taken) begin
         rsp_stall <= 1'b1;
         hold_left <= 400;
         hold_taken <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            mode_left <= $urandom_range(20, 120);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 9) < 3);
            default: rsp_stall <= ($urandom_range(0, 9) < 7);
         endcase
      end
   end

   task automatic send(mau_pkg::req_type_s_type item, bit typed,
                       mau_pkg::rsp_payload_type res);
      if (burst_left == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(0, 8)) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_payload = item;
      drv_typed = typed;
      drv_result = res;
      req_valid = 1'b1;
      do @(posedge clock); while (!(req_valid && !req_stall));
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid = 1'b0;
      wait (result_q.size() == 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_modulus(logic [30:0] value);
      drain();
      csr_write_enable = 1'b1;
      csr_write_data = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   function automatic logic [30:0] rand_operand(logic [30:0] m);
      case ($urandom_range(0, 9))
         0: return 31'd0;
         1: return (m == 0) ? 31'd0 : m - 1;
         2: return m;
         3: return OPND_MAX;
         4, 5: return (m < 2) ? 31'd0 : 31'($urandom_range(0, m - 1));
         default: return 31'($urandom_range(0, OPND_MAX));
      endcase
   endfunction

   function automatic mau_pkg::req_type_s_type rand_item(logic [30:0] m);
      mau_pkg::req_type_s_type r;
      int pick;
      pick = $urandom_range(0, 99);
      r.operand_a = rand_operand(m);
      r.operand_b = rand_operand(m);
      r.raw_value = {$urandom, $urandom};
      r.exponent = 63'($urandom_range(0, 300));
      if (pick < 10) begin
         r.req_type = mau_pkg::OP_REDUCE;
         if ($urandom_range(0, 3) == 0) r.raw_value = 64'($signed($urandom_range(0, 20)) - 10);
      end else if (pick < 22) r.req_type = mau_pkg::OP_ADD;
      else if (pick < 34) r.req_type = mau_pkg::OP_SUB;
      else if (pick < 46) r.req_type = mau_pkg::OP_MUL;
      else if (pick < 49) r.req_type = mau_pkg::OP_DIV;
      else if (pick < 63) begin
         r.req_type = mau_pkg::OP_POW;
         // full-width exponents are slow; keep them rare
         if ($urandom_range(0, 14) == 0) r.exponent = 63'({$urandom, $urandom} >> 1);
      end else if (pick < 66) r.req_type = mau_pkg::OP_INV;
      else if (pick < 72) r.req_type = mau_pkg::OP_NEG;
      else if (pick < 80) r.req_type = mau_pkg::OP_INC;
      else if (pick < 88) r.req_type = mau_pkg::OP_DEC;
      else if (pick < 98) begin
         r.req_type = mau_pkg::OP_EQUAL;
         if ($urandom_range(0, 1) == 0) r.operand_b = r.operand_a;
      end else r.req_type = 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      return r;
   endfunction

   initial begin
      mau_pkg::req_type_s_type item;
      mau_pkg::rsp_payload_type res;
      logic [30:0] mod_list[$];
      int ph;

      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      drv_typed = 1'b0;
      drv_result = '0;
      long_hold_req = 1'b0;
      burst_left = 0;

      // reset modulus 1000000007 throughout the table
      rows.push_back('{mau_pkg::OP_REDUCE, 0, 0, 64'h7FFFFFFFFFFFFFFF, 0, 0, 0, 0});
      rows.push_back('{mau_pkg::OP_REDUCE, 0, 0, 64'hFFFFFFFFFFFFFFFF, 0, 1,
                       31'd1000000006, 0});
      rows.push_back('{mau_pkg::OP_REDUCE, 0, 0, 64'h8000000000000000, 0, 0, 0, 0});
      rows.push_back('{mau_pkg::OP_REDUCE, 0, 0, 64'd0, 0, 1, 0, 0});
      rows.push_back('{mau_pkg::OP_ADD, OPND_MAX, OPND_MAX, 0, 0, 0, 0, 0});
      rows.push_back('{mau_pkg::OP_ADD, 0, 0, 0, 0, 1, 0, 0});
      rows.push_back('{mau_pkg::OP_SUB, 0, 1, 0, 0, 1, 31'd1000000006, 0});
      rows.push_back('{mau_pkg::OP_MUL, OPND_MAX, OPND_MAX, 0, 0, 0, 0, 0});
      rows.push_back('{mau_pkg::OP_DIV, 5, 0, 0, 0, 1, 0, 0});         // divide by zero
      rows.push_back('{mau_pkg::OP_DIV, 6, 3, 0, 0, 0, 0, 0});
      rows.push_back('{mau_pkg::OP_POW, 0, 0, 0, 0, 1, 1, 0});         // zero to the zero
      rows.push_back('{mau_pkg::OP_POW, 2, 0, 0, 10, 1, 1024, 0});
      rows.push_back('{mau_pkg::OP_POW, OPND_MAX, 0, 0, 63'h7FFFFFFFFFFFFFFF, 0, 0, 0});
      rows.push_back('{mau_pkg::OP_INV, 0, 0, 0, 0, 1, 0, 0});
      rows.push_back('{mau_pkg::OP_INV, 1, 0, 0, 0, 1, 1, 0});
      rows.push_back('{mau_pkg::OP_INV, OPND_MAX, 0, 0, 0, 0, 0, 0});
      rows.push_back('{mau_pkg::OP_NEG, 0, 0, 0, 0, 1, 0, 0});
      rows.push_back('{mau_pkg::OP_NEG, 1, 0, 0, 0, 1, 31'd1000000006, 0});
      rows.push_back('{mau_pkg::OP_INC, 31'd1000000006, 0, 0, 0, 1, 0, 0});
      rows.push_back('{mau_pkg::OP_INC, OPND_MAX, 0, 0, 0, 0, 0, 0});
      rows.push_back('{mau_pkg::OP_DEC, 0, 0, 0, 0, 1, 31'd1000000006, 0});
      rows.push_back('{mau_pkg::OP_EQUAL, 5, 5, 0, 0, 1, 0, 1});
      rows.push_back('{mau_pkg::OP_EQUAL, 5, 31'd1000000012, 0, 0, 1, 0, 1});
      rows.push_back('{mau_pkg::OP_EQUAL, 0, OPND_MAX, 0, 0, 0, 0, 0});
      rows.push_back('{OP_UNUSED_LO, 7, 7, 64'd99, 3, 1, 0, 0});
      rows.push_back('{OP_UNUSED_HI, OPND_MAX, OPND_MAX, 64'hFFFFFFFFFFFFFFFF,
                       63'h7FFFFFFFFFFFFFFF, 1, 0, 0});

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (rows[i]) begin
         item.req_type = rows[i].kind;
         item.operand_a = rows[i].a;
         item.operand_b = rows[i].b;
         item.raw_value = rows[i].raw;
         item.exponent = rows[i].e;
         res.residue = rows[i].res;
         res.equal_flag = rows[i].flag;
         send(item, rows[i].typed, res);
      end

      mod_list = {RESET_MOD, 31'd2, 31'd0, 31'd1, 31'h7FFFFFFF, 31'd3, 31'd65537,
                  31'd998244353, 31'($urandom_range(2, 32'h7FFFFFFF)), RESET_MOD};
      res = '0;
      for (ph = 0; ph < mod_list.size(); ph++) begin
         if (ph > 0) write_modulus(mod_list[ph]);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // long receiver hold while requests keep coming
            if (ph == 2 && n == 10) long_hold_req = 1'b1;
            // sender waits for every outstanding response once
            if (ph == 4 && n == 50) drain();
            send(rand_item(mod_list[ph]), 1'b0, res);
         end
      end

      req_valid = 1'b0;
      wait (result_q.size() == 0);
      repeat (50) @(posedge clock);
      if (error_count == 0) begin
         $display("modular_arithmetic_unit regression: pass");
      end else begin
         $display("modular_arithmetic_unit regression: fail");
      end
      $finish;
   end

endmodule

[sim.f]
sv/mau_pkg.sv
sv/mau_reducer.sv
sv/mau_datapath.sv
sv/mau_controller.sv
sv/modular_arithmetic_unit.sv
sv/mau_checker.sv
verif/tb_modular_arithmetic_unit.sv
